// ----- rtl/pfde_pkg.sv -----
// Shared types, constants, glyph ROM and microcode ROM of the draw engine.
`default_nettype none
package pfde_pkg;

  typedef struct packed {
    logic [1:0] mode;
    logic [6:0] col_x;
    logic [5:0] row_y;
    logic [1:0] pixel_op;
    logic [2:0] text_page;
    logic [7:0] char_code;
  } req_t;

  typedef struct packed {
    logic       is_data;
    logic [7:0] lcd_byte;
    logic       last;
  } lcd_t;

  // request modes
  localparam logic [1:0] MODE_PIXEL = 2'd0;
  localparam logic [1:0] MODE_TEXT  = 2'd1;
  localparam logic [1:0] MODE_CHAR  = 2'd2;

  // pixel operations
  localparam logic [1:0] POP_CLEAR  = 2'd0;
  localparam logic [1:0] POP_SET    = 2'd1;
  localparam logic [1:0] POP_INVERT = 2'd2;

  // controller command bases
  localparam logic [7:0] CMD_PAGE   = 8'hB0;
  localparam logic [7:0] CMD_COL_HI = 8'h10;
  localparam logic [7:0] CMD_COL_LO = 8'h0F;

  localparam logic [7:0] FIRST_GLYPH = 8'd32;  // space
  localparam logic [7:0] END_GLYPH   = 8'd131;
  localparam logic [2:0] GLYPH_WIDTH = 3'd5;   // last column index is the blank one

  typedef logic [4:0][7:0] glyph_t;  // element 4 is the leftmost column

  typedef logic [3:0] step_t;

  localparam step_t ST_FETCH    = 4'd0;
  localparam step_t ST_PIX      = 4'd1;
  localparam step_t ST_PIX_ADDR = 4'd2;
  localparam step_t ST_PIX_RD   = 4'd3;
  localparam step_t ST_PIX_MOD  = 4'd4;
  localparam step_t ST_PIX_WR   = 4'd5;
  localparam step_t ST_PIX_CHI  = 4'd6;
  localparam step_t ST_PIX_CLO  = 4'd7;
  localparam step_t ST_PIX_DAT  = 4'd8;
  localparam step_t ST_POS      = 4'd9;
  localparam step_t ST_POS_CUR  = 4'd10;
  localparam step_t ST_POS_CHI  = 4'd11;
  localparam step_t ST_POS_CLO  = 4'd12;
  localparam step_t ST_CHR      = 4'd13;
  localparam step_t ST_CHR_COL  = 4'd14;

  typedef enum logic [1:0] {RAW_NONE, RAW_PIX, RAW_TXT} raw_sel_t;
  typedef enum logic [1:0] {WR_NONE, WR_PIXEL, WR_CHAR} wr_sel_t;
  typedef enum logic [2:0] {
    EM_NONE, EM_PAGE_PIX, EM_PAGE_TXT, EM_COL_HI, EM_COL_LO, EM_PIXEL, EM_CHAR
  } emit_t;
  typedef enum logic [1:0] {LS_NO, LS_YES, LS_COL} last_sel_t;
  typedef enum logic [1:0] {SQ_NEXT, SQ_GOTO, SQ_LOOP, SQ_DISPATCH} seq_t;

  typedef struct packed {
    logic      wait_in;
    raw_sel_t  raw_sel;
    logic      ld_addr;
    logic      ld_cursor;
    logic      mem_rd;
    logic      ld_data;
    wr_sel_t   mem_wr;
    emit_t     emit;
    last_sel_t last;
    logic      ld_glyph;
    logic      clr_col;
    logic      adv_col;
    seq_t      seq;
    step_t     target;
  } ctrl_t;

  typedef struct packed {
    logic       req_valid;
    logic       out_blocked;
    logic       clearing;
    logic       col_last;
    logic [1:0] mode;
  } stat_t;

  function automatic ctrl_t ucode(input step_t step);
    ctrl_t cw;
    cw = '0;
    case (step)
      ST_FETCH: begin
        cw.wait_in = 1'b1;
        cw.seq     = SQ_DISPATCH;
      end
      ST_PIX:      cw.raw_sel = RAW_PIX;
      ST_PIX_ADDR: cw.ld_addr = 1'b1;
      ST_PIX_RD:   cw.mem_rd  = 1'b1;
      ST_PIX_MOD:  cw.ld_data = 1'b1;
      ST_PIX_WR: begin
        cw.mem_wr = WR_PIXEL;
        cw.emit   = EM_PAGE_PIX;
      end
      ST_PIX_CHI:  cw.emit = EM_COL_HI;
      ST_PIX_CLO:  cw.emit = EM_COL_LO;
      ST_PIX_DAT: begin
        cw.emit   = EM_PIXEL;
        cw.last   = LS_YES;
        cw.seq    = SQ_GOTO;
        cw.target = ST_FETCH;
      end
      ST_POS:      cw.raw_sel = RAW_TXT;
      ST_POS_CUR: begin
        cw.ld_cursor = 1'b1;
        cw.emit      = EM_PAGE_TXT;
      end
      ST_POS_CHI:  cw.emit = EM_COL_HI;
      ST_POS_CLO: begin
        cw.emit   = EM_COL_LO;
        cw.last   = LS_YES;
        cw.seq    = SQ_GOTO;
        cw.target = ST_FETCH;
      end
      ST_CHR: begin
        cw.ld_glyph = 1'b1;
        cw.clr_col  = 1'b1;
      end
      ST_CHR_COL: begin
        cw.mem_wr  = WR_CHAR;
        cw.emit    = EM_CHAR;
        cw.last    = LS_COL;
        cw.adv_col = 1'b1;
        cw.seq     = SQ_LOOP;
        cw.target  = ST_CHR_COL;
      end
      default: begin
        cw.seq    = SQ_GOTO;
        cw.target = ST_FETCH;
      end
    endcase
    return cw;
  endfunction

  // 5x7 font, columns left to right; codes without a glyph are blank
  function automatic glyph_t glyph_cols(input logic [7:0] code);
    glyph_t g;
    case (code)
      8'd33:  g = 40'h00004F0000;
      8'd34:  g = 40'h0007000700;
      8'd35:  g = 40'h147F147F14;
      8'd36:  g = 40'h242A7F2A12;
      8'd37:  g = 40'h2313086462;
      8'd38:  g = 40'h3649552240;
      8'd39:  g = 40'h0005030000;
      8'd40:  g = 40'h001C224100;
      8'd41:  g = 40'h0041221C00;
      8'd42:  g = 40'h14083E0814;
      8'd43:  g = 40'h08083E0808;
      8'd44:  g = 40'h0050300000;
      8'd45:  g = 40'h0808080808;
      8'd46:  g = 40'h0060600000;
      8'd47:  g = 40'h2010080402;
      8'd48:  g = 40'h3E5149453E;
      8'd49:  g = 40'h00427F4000;
      8'd50:  g = 40'h4261514946;
      8'd51:  g = 40'h2141454B31;
      8'd52:  g = 40'h1814127F10;
      8'd53:  g = 40'h2745454539;
      8'd54:  g = 40'h3C4A494930;
      8'd55:  g = 40'h0171090503;
      8'd56:  g = 40'h3649494936;
      8'd57:  g = 40'h064949291E;
      8'd58:  g = 40'h0036360000;
      8'd59:  g = 40'h0056360000;
      8'd60:  g = 40'h0814224100;
      8'd61:  g = 40'h1414141414;
      8'd62:  g = 40'h0041221408;
      8'd63:  g = 40'h020151093E;
      8'd64:  g = 40'h324979413E;
      8'd65:  g = 40'h7E1111117E;
      8'd66:  g = 40'h7F49494936;
      8'd67:  g = 40'h3E41414122;
      8'd68:  g = 40'h7F4141221C;
      8'd69:  g = 40'h7F49494941;
      8'd70:  g = 40'h7F09090901;
      8'd71:  g = 40'h3E4149493A;
      8'd72:  g = 40'h7F0808087F;
      8'd73:  g = 40'h00417F4100;
      8'd74:  g = 40'h2040413F01;
      8'd75:  g = 40'h7F08142241;
      8'd76:  g = 40'h7F40404040;
      8'd77:  g = 40'h7F020C027F;
      8'd78:  g = 40'h7F0408107F;
      8'd79:  g = 40'h3E4141413E;
      8'd80:  g = 40'h7F09090906;
      8'd81:  g = 40'h3E4151215E;
      8'd82:  g = 40'h7F09192946;
      8'd83:  g = 40'h4649494931;
      8'd84:  g = 40'h01017F0101;
      8'd85:  g = 40'h3F4040403F;
      8'd86:  g = 40'h1F2040201F;
      8'd87:  g = 40'h3F4070403F;
      8'd88:  g = 40'h6314081463;
      8'd89:  g = 40'h0708700807;
      8'd90:  g = 40'h6151494543;
      8'd91:  g = 40'h007F414100;
      8'd92:  g = 40'h0204081020;
      8'd93:  g = 40'h0041417F00;
      8'd94:  g = 40'h0402010204;
      8'd95:  g = 40'h4040404040;
      8'd96:  g = 40'h0001020400;
      8'd97:  g = 40'h2054545478;
      8'd98:  g = 40'h7F44444438;
      8'd99:  g = 40'h3844444420;
      8'd100: g = 40'h384444487F;
      8'd101: g = 40'h3854545418;
      8'd102: g = 40'h087E090102;
      8'd103: g = 40'h0C5252523E;
      8'd104: g = 40'h7F08040478;
      8'd105: g = 40'h00447D4000;
      8'd106: g = 40'h2040443D00;
      8'd107: g = 40'h7F10284400;
      8'd108: g = 40'h00417F4000;
      8'd109: g = 40'h7C04180478;
      8'd110: g = 40'h7C08040478;
      8'd111: g = 40'h3844444438;
      8'd112: g = 40'h7C14141408;
      8'd113: g = 40'h081414187C;
      8'd114: g = 40'h7C08040408;
      8'd115: g = 40'h4854545420;
      8'd116: g = 40'h043F444020;
      8'd117: g = 40'h3C4040207C;
      8'd118: g = 40'h1C2040201C;
      8'd119: g = 40'h3C4020403C;
      8'd120: g = 40'h4428102844;
      8'd121: g = 40'h0C5050503C;
      8'd122: g = 40'h4464544C44;
      8'd123: g = 40'h0008364100;
      8'd124: g = 40'h00007F0000;
      8'd125: g = 40'h0041360800;
      8'd126: g = 40'h0C041C1018;
      8'd128: g = 40'h08082A1C08;
      8'd129: g = 40'h081C2A0808;
      8'd130: g = 40'h0705070000;
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/pfde_fbuf.sv -----
// Frame buffer RAM with a clearing sweep after reset.
`default_nettype none
module pfde_fbuf #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [7:0]    rd_data,
  output logic               clearing
);

  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(DEPTH - 1)) clearing <= 1'b0;
      clr_addr <= AW'(clr_addr + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= 8'h00;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ----- rtl/pfde_seq.sv -----
// Microcode sequencer: step counter, control ROM and branch logic.
`default_nettype none
module pfde_seq (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire pfde_pkg::stat_t st,
  output pfde_pkg::ctrl_t      cw,
  output logic                 go
);

  pfde_pkg::step_t step, step_next;

  assign cw = pfde_pkg::ucode(step);

  // a step holds while it waits for a request or the end of the clearing sweep, or for room in the output register
  assign go = !(cw.wait_in && (!st.req_valid || st.clearing)) &&
              !((cw.emit != pfde_pkg::EM_NONE) && st.out_blocked);

  always_comb begin
    step_next = step;
    if (go) begin
      case (cw.seq)
        pfde_pkg::SQ_NEXT: step_next = pfde_pkg::step_t'(step + 1'b1);
        pfde_pkg::SQ_GOTO: step_next = cw.target;
        pfde_pkg::SQ_LOOP: step_next = st.col_last ? pfde_pkg::ST_FETCH : cw.target;
        pfde_pkg::SQ_DISPATCH: begin
          case (st.mode)
            pfde_pkg::MODE_PIXEL: step_next = pfde_pkg::ST_PIX;
            pfde_pkg::MODE_TEXT:  step_next = pfde_pkg::ST_POS;
            pfde_pkg::MODE_CHAR:  step_next = pfde_pkg::ST_CHR;
            default:              step_next = pfde_pkg::ST_FETCH;
          endcase
        end
        default: step_next = pfde_pkg::ST_FETCH;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) step <= pfde_pkg::ST_FETCH;
    else     step <= step_next;
  end

endmodule
`default_nettype wire

// ----- rtl/pfde_dp.sv -----
// Datapath: request latch, address reduction, cursor, pixel modify, output register.
`default_nettype none
module pfde_dp #(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8,
  parameter int STORE   = COLUMNS * PAGES,
  parameter int AW      = $clog2(STORE)
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire pfde_pkg::ctrl_t cw,
  input  wire logic            go,
  input  wire pfde_pkg::req_t  cmd,
  input  wire logic            lcd_stall,
  output logic                 lcd_valid,
  output pfde_pkg::lcd_t       lcd,
  output logic                 out_blocked,
  output logic                 col_last,
  output logic [1:0]           mode,
  output logic                 wr_en,
  output logic [AW-1:0]        wr_addr,
  output logic [7:0]           wr_data,
  output logic                 rd_en,
  output logic [AW-1:0]        rd_addr,
  input  wire logic [7:0]      rd_data
);

  localparam int RAW_W = $clog2(7 * COLUMNS + 128);
  localparam int TW    = RAW_W + 7;

  pfde_pkg::req_t   item;
  pfde_pkg::glyph_t glyph;
  logic [RAW_W-1:0] raw, raw_next;
  logic [AW-1:0]    addr, cursor, reduced;
  logic [7:0]       data, data_next, mask, col_byte;
  logic [2:0]       col, pg;
  logic [TW-1:0]    acc, thr;
  logic             lcd_is_data;
  logic [7:0]       lcd_data;

  assign mode        = cmd.mode;
  assign out_blocked = lcd_valid && lcd_stall;
  assign col_last    = (col == pfde_pkg::GLYPH_WIDTH);

  // linear address before the wrap
  always_comb begin
    pg       = (cw.raw_sel == pfde_pkg::RAW_TXT) ? item.text_page : item.row_y[5:3];
    raw_next = RAW_W'(RAW_W'(pg) * RAW_W'(COLUMNS) + RAW_W'(item.col_x));
  end

  // wrap modulo the store size by restoring subtraction, quotient below 128
  always_comb begin
    acc = TW'(raw);
    thr = '0;
    for (int k = 6; k >= 0; k--) begin
      thr = TW'(STORE) << k;
      if (acc >= thr) acc = acc - thr;
    end
    reduced = acc[AW-1:0];
  end

  always_comb begin
    mask = 8'h01 << item.row_y[2:0];
    case (item.pixel_op)
      pfde_pkg::POP_CLEAR:  data_next = rd_data & ~mask;
      pfde_pkg::POP_SET:    data_next = rd_data | mask;
      pfde_pkg::POP_INVERT: data_next = rd_data ^ mask;
      default:              data_next = rd_data;
    endcase
  end

  // blank sixth column
  assign col_byte = (col < pfde_pkg::GLYPH_WIDTH) ? glyph[3'd4 - col] : 8'h00;

  assign rd_en   = go && cw.mem_rd;
  assign rd_addr = addr;
  assign wr_en   = go && (cw.mem_wr != pfde_pkg::WR_NONE);
  assign wr_addr = (cw.mem_wr == pfde_pkg::WR_PIXEL) ? addr : cursor;
  assign wr_data = (cw.mem_wr == pfde_pkg::WR_PIXEL) ? data : col_byte;

  always_comb begin
    lcd_is_data = 1'b0;
    lcd_data    = 8'h00;
    case (cw.emit)
      pfde_pkg::EM_PAGE_PIX: lcd_data = pfde_pkg::CMD_PAGE | {5'b0, item.row_y[5:3]};
      pfde_pkg::EM_PAGE_TXT: lcd_data = pfde_pkg::CMD_PAGE | {5'b0, item.text_page};
      pfde_pkg::EM_COL_HI:   lcd_data = pfde_pkg::CMD_COL_HI | {5'b0, item.col_x[6:4]};
      pfde_pkg::EM_COL_LO:   lcd_data = pfde_pkg::CMD_COL_LO & {4'b0, item.col_x[3:0]};
      pfde_pkg::EM_PIXEL: begin
        lcd_is_data = 1'b1;
        lcd_data    = data;
      end
      pfde_pkg::EM_CHAR: begin
        lcd_is_data = 1'b1;
        lcd_data    = col_byte;
      end
      default: lcd_data = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (go) begin
      if (cw.wait_in) item <= cmd;
      if (cw.raw_sel != pfde_pkg::RAW_NONE) raw <= raw_next;
      if (cw.ld_addr) addr <= reduced;
      if (cw.ld_data) data <= data_next;
      if (cw.ld_glyph) glyph <= pfde_pkg::glyph_cols(item.char_code);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
      col    <= '0;
    end else if (go) begin
      if (cw.ld_cursor) cursor <= reduced;
      if (cw.clr_col) col <= '0;
      if (cw.adv_col) begin
        col    <= 3'(col + 1'b1);
        cursor <= (cursor == AW'(STORE - 1)) ? '0 : AW'(cursor + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lcd_valid <= 1'b0;
    end else if (go && (cw.emit != pfde_pkg::EM_NONE)) begin
      lcd_valid <= 1'b1;
    end else if (!lcd_stall) begin
      lcd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && (cw.emit != pfde_pkg::EM_NONE)) begin
      lcd.is_data  <= lcd_is_data;
      lcd.lcd_byte <= lcd_data;
      case (cw.last)
        pfde_pkg::LS_YES: lcd.last <= 1'b1;
        pfde_pkg::LS_COL: lcd.last <= col_last;
        default:          lcd.last <= 1'b0;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/page_framebuffer_draw_engine.sv -----
// Top level of the page-mode monochrome frame buffer draw engine.
`default_nettype none
// Draw engine for a page-organized monochrome display: it keeps a frame buffer
// of PAGES pages by COLUMNS column bytes (bit k of a byte is pixel row
// 8*page+k) and a text cursor, and turns each drawing request on the cmd
// channel into command and data bytes on the lcd channel, with last marking
// the final byte of a request. Mode 0 does a clear/set/invert/keep on one
// pixel and sends page, column-high and column-low commands and the new byte;
// mode 1 moves the cursor and sends the three commands; mode 2 writes a 5x7
// glyph plus one blank column at the cursor and sends the six data bytes;
// mode 3 is taken and dropped. Frame addresses and the cursor wrap at
// COLUMNS*PAGES. Control runs from a 15-step microcode ROM, one step per
// clock unless a step is held, one request at a time; each request begins
// with its fetch step, and a character then runs a glyph load step and one
// step per column, bounded by the single frame RAM write port. Each step
// that emits a byte waits while the output register holds an untaken
// transfer. After reset the RAM is swept to zero, one byte a cycle, over all
// COLUMNS*PAGES bytes (1024 by default); cmd_stall stays high meanwhile.
module page_framebuffer_draw_engine #(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cmd_valid,
  output logic                cmd_stall,
  input  wire pfde_pkg::req_t cmd,
  output logic                lcd_valid,
  input  wire logic           lcd_stall,
  output pfde_pkg::lcd_t      lcd
);

  localparam int STORE = COLUMNS * PAGES;
  localparam int AW    = $clog2(STORE);

  pfde_pkg::ctrl_t cw;
  pfde_pkg::stat_t st;
  logic            go;
  logic            clearing;
  logic            out_blocked, col_last;
  logic [1:0]      mode;
  logic            wr_en, rd_en;
  logic [AW-1:0]   wr_addr, rd_addr;
  logic [7:0]      wr_data, rd_data;

  // a request transfers only in the fetch step, once the sweep is done
  assign cmd_stall = !(cw.wait_in && !clearing);

  assign st.req_valid   = cmd_valid;
  assign st.out_blocked = out_blocked;
  assign st.clearing    = clearing;
  assign st.col_last    = col_last;
  assign st.mode        = mode;

  pfde_seq u_seq (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cw  (cw),
    .go  (go)
  );

  pfde_dp #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES),
    .STORE   (STORE),
    .AW      (AW)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cw          (cw),
    .go          (go),
    .cmd         (cmd),
    .lcd_stall   (lcd_stall),
    .lcd_valid   (lcd_valid),
    .lcd         (lcd),
    .out_blocked (out_blocked),
    .col_last    (col_last),
    .mode        (mode),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data)
  );

  // frame RAM; the sweep owns the write port until it finishes
  pfde_fbuf #(
    .DEPTH (STORE),
    .AW    (AW)
  ) u_fbuf (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .clearing (clearing)
  );

endmodule
`default_nettype wire
